### hw/rtl/gct_pkg.sv
// Package for the Gram congruence transform block.
// Holds size constants, controller state and command/status structs.
// No dependencies.
package gct_pkg;

  localparam int RANK_DEF = 5;
  localparam int RANK_MAX = 8;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_STORE,
    ST_DIV1,
    ST_DIV2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_acc;
    logic mul1;
    logic mul2;
    logic acc;
    logic tri_wr;
    logic div1_start;
    logic div2_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/gct_divider.sv
// Iterative signed 64-bit divide by unsigned 31-bit value, truncating toward zero.
// One quotient bit per cycle. Uses gct_pkg only for nothing; standalone.
module gct_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [30:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [30:0] d_r, d_nxt;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    d_nxt    = d_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[30:0], q_r[63]};
    trial    = {1'b0, shifted} - {2'b00, d_r};
    if (start) begin
      neg_nxt  = dividend[63];
      q_nxt    = dividend[63] ? (64'd0 - dividend) : dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
      d_nxt    = (divisor == '0) ? 31'd1 : divisor;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    d_r   <= d_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? (64'd0 - q_r) : q_r;

endmodule

### hw/rtl/gct_datapath.sv
// Datapath: operand stores, two-step multiply, accumulator, triangle store,
// divider and output register. Depends on gct_pkg and gct_divider.
module gct_datapath #(
  parameter int RANK = gct_pkg::RANK_DEF,
  localparam int SLOTS = RANK * RANK,
  localparam int TRI   = RANK * (RANK + 1) / 2,
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int TW    = (TRI > 1) ? $clog2(TRI) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  // load side
  input  logic              ld_wr,
  input  logic [AW-1:0]     ld_addr,
  input  logic [31:0]       form_in,
  input  logic [31:0]       trans_in,
  // compute addressing
  input  logic [AW-1:0]     q_addr,
  input  logic [AW-1:0]     gi_addr,
  input  logic [AW-1:0]     gj_addr,
  input  logic [TW-1:0]     tri_addr,
  input  logic [2:0]        o_row,
  input  logic [2:0]        o_col,
  input  logic              o_last,
  input  logic [30:0]       denom,
  input  gct_pkg::cmd_t     cmd,
  output gct_pkg::sts_t     sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_row_index,
  output logic [2:0]        out_col_index,
  output logic [63:0]       out_result_entry,
  output logic              out_result_last
);

  logic [31:0] form_mem  [SLOTS];
  logic [31:0] trans_mem [SLOTS];
  logic [31:0] trans_mem2[SLOTS];
  logic [63:0] tri_mem   [TRI];

  logic [31:0] q_rd_r, gi_rd_r, gj_rd_r;
  logic [63:0] tri_rd_r;
  logic [63:0] p1_r, p2_r, acc_r;
  logic [63:0] p1_nxt, p2_nxt;
  logic [63:0] p2_lo;
  logic [31:0] p2_hi;

  // A read of the slot written by the same beat returns the new pair.
  always_ff @(posedge clk) begin
    if (ld_wr) begin
      form_mem[ld_addr]   <= form_in;
      trans_mem[ld_addr]  <= trans_in;
      trans_mem2[ld_addr] <= trans_in;
    end
    q_rd_r  <= (ld_wr && ld_addr == q_addr)  ? form_in  : form_mem[q_addr];
    gi_rd_r <= (ld_wr && ld_addr == gi_addr) ? trans_in : trans_mem[gi_addr];
    gj_rd_r <= (ld_wr && ld_addr == gj_addr) ? trans_in : trans_mem2[gj_addr];
  end

  // Q*g[k][i] in step one, times g[l][j] in step two; low 64 bits only.
  // Step two splits p1 into halves: low half times g in full, high half
  // times g only to 32 bits, shifted up.
  assign p1_nxt = 64'($signed(q_rd_r) * $signed(gi_rd_r));
  assign p2_lo  = 64'($signed({1'b0, p1_r[31:0]}) * $signed(gj_rd_r));
  assign p2_hi  = p1_r[63:32] * gj_rd_r;
  assign p2_nxt = p2_lo + {p2_hi, 32'd0};

  always_ff @(posedge clk) begin
    if (cmd.mul1) p1_r <= p1_nxt;
    if (cmd.mul2) p2_r <= p2_nxt;
    if (cmd.clr_acc) acc_r <= '0;
    else if (cmd.acc) acc_r <= acc_r + p2_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.tri_wr) tri_mem[tri_addr] <= acc_r;
    tri_rd_r <= tri_mem[tri_addr];
  end

  logic        dv_start, dv_busy, dv_done;
  logic [63:0] dv_in, dv_q;

  assign dv_start = cmd.div1_start | cmd.div2_start;
  assign dv_in    = cmd.div1_start ? tri_rd_r : dv_q;

  gct_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_in),
    .divisor  (denom),
    .busy     (dv_busy),
    .done     (dv_done),
    .quotient (dv_q)
  );

  logic        ov_r, ov_nxt;
  logic [2:0]  row_r, col_r;
  logic [63:0] val_r;
  logic        last_r;

  always_comb begin
    ov_nxt = ov_r;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    if (cmd.out_load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= ov_nxt;
    if (cmd.out_load) begin
      row_r  <= o_row;
      col_r  <= o_col;
      val_r  <= dv_q;
      last_r <= o_last;
    end
  end

  assign sts.div_done    = dv_done & ~dv_busy;
  assign sts.out_free    = ~ov_r | out_ready;
  assign out_valid       = ov_r;
  assign out_row_index   = row_r;
  assign out_col_index   = col_r;
  assign out_result_entry = val_r;
  assign out_result_last = last_r;

endmodule

### hw/rtl/gct_ctrl.sv
// Controller FSM: load pointer, loop counters over (i,j,k,l) and emission.
// Depends on gct_pkg.
module gct_ctrl #(
  parameter int RANK = gct_pkg::RANK_DEF,
  localparam int SLOTS = RANK * RANK,
  localparam int TRI   = RANK * (RANK + 1) / 2,
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int TW    = (TRI > 1) ? $clog2(TRI) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_load_last,
  output logic          ld_wr,
  output logic [AW-1:0] ld_addr,
  output logic [AW-1:0] q_addr,
  output logic [AW-1:0] gi_addr,
  output logic [AW-1:0] gj_addr,
  output logic [TW-1:0] tri_addr,
  output logic [2:0]    o_row,
  output logic [2:0]    o_col,
  output logic          o_last,
  output gct_pkg::cmd_t cmd,
  input  gct_pkg::sts_t sts
);

  localparam logic [2:0] RMAX = 3'(RANK - 1);
  localparam logic [AW-1:0] SMAX = AW'(SLOTS - 1);

  // Phases of ST_DIV1: wait for the triangle read, start pass one, run.
  localparam logic [1:0] DPH_WAIT  = 2'd0;
  localparam logic [1:0] DPH_START = 2'd1;
  localparam logic [1:0] DPH_RUN   = 2'd2;

  gct_pkg::state_t st_r, st_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, l_r, l_nxt;
  logic       fin_r, fin_nxt; // last (k,l) term in flight

  logic       acc_go;
  logic [5:0] ti;

  assign acc_go = in_valid & in_ready;

  // Triangle index: i*RANK - i*(i-1)/2 + (j-i), using the smaller of (i,j) as row.
  logic [2:0] ra, cb;
  always_comb begin
    ra = (j_r >= i_r) ? i_r : j_r;
    cb = (j_r >= i_r) ? j_r : i_r;
    ti = 6'(ra * RANK) - 6'((ra * (ra - 3'd1)) >> 1) + 6'(cb - ra);
    if (ra == 3'd0) ti = 6'(cb);
  end

  always_comb begin
    st_nxt  = st_r;
    pos_nxt = pos_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; l_nxt = l_r;
    fin_nxt = fin_r;
    unique case (st_r)
      gct_pkg::ST_LOAD: begin
        if (acc_go) begin
          pos_nxt = (pos_r == SMAX) ? '0 : pos_r + AW'(1);
          if (in_load_last) begin
            pos_nxt = '0;
            st_nxt = gct_pkg::ST_MUL1;
            i_nxt = '0; j_nxt = '0; k_nxt = '0; l_nxt = '0;
          end
        end
      end
      gct_pkg::ST_MUL1: st_nxt = gct_pkg::ST_MUL2;
      gct_pkg::ST_MUL2: st_nxt = gct_pkg::ST_ACC;
      gct_pkg::ST_ACC: begin
        fin_nxt = (k_r == RMAX) && (l_r == RMAX);
        if (l_r == RMAX) begin
          l_nxt = '0;
          k_nxt = k_r + 3'd1;
        end else begin
          l_nxt = l_r + 3'd1;
        end
        st_nxt = fin_nxt ? gct_pkg::ST_STORE : gct_pkg::ST_MUL1;
      end
      gct_pkg::ST_STORE: begin
        k_nxt = '0; l_nxt = '0;
        if (j_r == RMAX) begin
          if (i_r == RMAX) begin
            i_nxt = '0; j_nxt = '0;
            st_nxt = gct_pkg::ST_DIV1;
          end else begin
            i_nxt = i_r + 3'd1; j_nxt = i_r + 3'd1;
            st_nxt = gct_pkg::ST_MUL1;
          end
        end else begin
          j_nxt = j_r + 3'd1;
          st_nxt = gct_pkg::ST_MUL1;
        end
      end
      gct_pkg::ST_DIV1: if (sts.div_done) st_nxt = gct_pkg::ST_DIV2;
      gct_pkg::ST_DIV2: if (sts.div_done) st_nxt = gct_pkg::ST_EMIT;
      gct_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          if (j_r == RMAX) begin
            j_nxt = '0;
            i_nxt = i_r + 3'd1;
          end else begin
            j_nxt = j_r + 3'd1;
          end
          st_nxt = (i_r == RMAX && j_r == RMAX) ? gct_pkg::ST_LOAD : gct_pkg::ST_DIV1;
        end
      end
      default: st_nxt = gct_pkg::ST_LOAD;
    endcase
  end

  // DIV1 lets the triangle read register in DPH_WAIT, starts pass one once, then pass two.
  logic [1:0] dph_r, dph_nxt;

  always_comb begin
    cmd = '0;
    dph_nxt = dph_r;
    unique case (st_r)
      gct_pkg::ST_MUL1: begin
        cmd.mul1 = 1'b1;
        cmd.clr_acc = (k_r == 3'd0) && (l_r == 3'd0);
      end
      gct_pkg::ST_MUL2:  cmd.mul2 = 1'b1;
      gct_pkg::ST_ACC:   cmd.acc = 1'b1;
      gct_pkg::ST_STORE: cmd.tri_wr = 1'b1;
      gct_pkg::ST_DIV1: begin
        if (dph_r == DPH_WAIT) begin
          dph_nxt = DPH_START;
        end else if (dph_r == DPH_START) begin
          cmd.div1_start = 1'b1;
          dph_nxt = DPH_RUN;
        end else if (sts.div_done) begin
          cmd.div2_start = 1'b1;
        end
      end
      gct_pkg::ST_DIV2: if (sts.div_done) dph_nxt = DPH_WAIT;
      gct_pkg::ST_EMIT: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  // ST_STORE needs acc settled: ACC adds p2 at its edge, so STORE writes acc_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gct_pkg::ST_LOAD;
      pos_r <= '0;
      i_r <= '0; j_r <= '0; k_r <= '0; l_r <= '0;
      fin_r <= 1'b0;
      dph_r <= DPH_WAIT;
    end else begin
      st_r <= st_nxt;
      pos_r <= pos_nxt;
      i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; l_r <= l_nxt;
      fin_r <= fin_nxt;
      dph_r <= dph_nxt;
    end
  end

  // Reads for the (k,l) term are issued while in ACC/STORE/LOAD preceding MUL1;
  // addresses come from the next-state counters so data is registered by MUL1.
  assign in_ready = (st_r == gct_pkg::ST_LOAD);
  assign ld_wr    = acc_go;
  assign ld_addr  = pos_r;
  assign q_addr   = AW'(k_nxt * RANK + l_nxt);
  assign gi_addr  = AW'(k_nxt * RANK + i_nxt);
  assign gj_addr  = AW'(l_nxt * RANK + j_nxt);
  assign tri_addr = TW'(ti);
  assign o_row    = i_r;
  assign o_col    = j_r;
  assign o_last   = (i_r == RMAX) && (j_r == RMAX);

endmodule

### hw/rtl/gram_congruence_transform_top.sv
// Top level of the Gram congruence transform: APB register, controller and datapath.
// Depends on gct_pkg, gct_ctrl, gct_datapath.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat per pair of entries of Q and g,
//    row-major, back to back. A beat with in_load_last high starts the work.
//  - in_ready then drops while the upper triangle is computed: RANK*(RANK+1)/2
//    entries, each RANK*RANK multiply-accumulate terms (MUL1, MUL2, ACC) plus one
//    STORE, set by the single shared two-step multiplier.
//  - Output channel (out_valid/out_ready): RANK*RANK beats, row-major, the final
//    beat flagged by out_result_last. Each entry takes a triangle read, two
//    passes of a one-bit-per-cycle divider and an emit step.
//  - A stalled receiver holds the output register; the next division still runs.
//  - Loading resumes as soon as the last entry sits in the output register.
//  - Config: denominator at byte address 0, written with psel/penable/pwrite;
//    reset value 1, zero is treated as 1.
//  - Reset (rst_n low, synchronous) empties the pipeline and returns the load
//    position to slot 0; matrix stores are undefined until loaded.
module gram_congruence_transform_top #(
  parameter int RANK = gct_pkg::RANK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_form_entry,
  input  logic [31:0] in_transform_entry,
  input  logic        in_load_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_row_index,
  output logic [2:0]  out_col_index,
  output logic [63:0] out_result_entry,
  output logic        out_result_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SLOTS = RANK * RANK;
  localparam int TRI   = RANK * (RANK + 1) / 2;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW    = (TRI > 1) ? $clog2(TRI) : 1;
  localparam logic [1:0] ADDR_DENOM = 2'd0;

  logic [30:0] denom_r;

  // Single register; writes elsewhere are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) denom_r <= 31'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_DENOM)
      denom_r <= cfg_pwdata[30:0];
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_DENOM) ? {1'b0, denom_r} : 32'd0;

  gct_pkg::cmd_t cmd;
  gct_pkg::sts_t sts;
  logic          ld_wr;
  logic [AW-1:0] ld_addr, q_addr, gi_addr, gj_addr;
  logic [TW-1:0] tri_addr;
  logic [2:0]    o_row, o_col;
  logic          o_last;

  gct_ctrl #(.RANK(RANK)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_load_last,
    .ld_wr, .ld_addr, .q_addr, .gi_addr, .gj_addr, .tri_addr,
    .o_row, .o_col, .o_last, .cmd, .sts
  );

  gct_datapath #(.RANK(RANK)) u_dp (
    .clk, .rst_n, .ld_wr, .ld_addr,
    .form_in  (in_form_entry),
    .trans_in (in_transform_entry),
    .q_addr, .gi_addr, .gj_addr, .tri_addr, .o_row, .o_col, .o_last,
    .denom (denom_r), .cmd, .sts,
    .out_valid, .out_ready, .out_row_index, .out_col_index,
    .out_result_entry, .out_result_last
  );

endmodule
